/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, sampled on clk, disabled under rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SWM_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication.
`define SWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg
// Types and constants of the star wildcard matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swm_pkg;

  localparam logic [7:0] STAR_BYTE  = 8'd42;
  localparam int         GROUP_SIZE = 16;

  typedef enum logic {
    CMD_PATTERN = 1'b0,
    CMD_NAME    = 1'b1
  } command_t;

  typedef struct packed {
    command_t   command;
    logic [7:0] char_value;
    logic       last_char;
  } item_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } result_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic       step;
    logic       start;
    logic       clear;
    logic       star;
    logic [7:0] ch;
  } swm_bcast_t;

  // Handed from one cell to the next.
  typedef struct packed {
    logic carry;
    logic skip;
    logic filled;
    logic star;
  } swm_link_t;

  localparam swm_link_t LINK_HEAD = '{carry: 1'b0, skip: 1'b0, filled: 1'b1, star: 1'b0};

endpackage

/* rtl/swm_cell.sv */
// ----------------------------------------------------------------------------
// swm_cell
// One pattern position: stored byte, fill bit and live bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_cell (
  input  logic               clk,
  input  logic               rst,
  input  swm_pkg::swm_bcast_t bcast,
  input  logic               wr,
  input  logic               start_live,
  input  swm_pkg::swm_link_t link_in,
  output swm_pkg::swm_link_t link_out,
  output logic               hit
);
  import swm_pkg::*;

  logic [7:0] pbyte;
  logic       starf;
  logic       filled;
  logic       act;

  logic act_eff;
  logic stay;
  logic carry;
  logic pre;
  logic act_next;

  always_comb begin
    act_eff  = bcast.start ? start_live : act;
    stay     = act_eff & filled & starf;
    carry    = act_eff & filled & ~starf & (pbyte == bcast.ch);
    // Stars are collapsed on load, so closure reaches one position only.
    pre      = stay | link_in.carry;
    act_next = pre | link_in.skip;
    link_out.carry  = carry;
    link_out.skip   = pre & starf & filled;
    link_out.filled = filled;
    link_out.star   = starf & filled;
    // End-of-pattern position sits just past the last filled cell.
    hit = act_next & link_in.filled & ~filled;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act    <= 1'b0;
      filled <= 1'b0;
    end else begin
      if (bcast.step) begin
        act <= act_next;
      end
      if (bcast.clear) begin
        filled <= wr;
      end else begin
        filled <= filled | wr;
      end
    end
    if (wr) begin
      pbyte <= bcast.ch;
      starf <= bcast.star;
    end
  end

endmodule

/* rtl/star_wildcard_matcher.sv */
// ----------------------------------------------------------------------------
// star_wildcard_matcher
// Glob matcher with '*' wildcards over a chain of position cells.
// ----------------------------------------------------------------------------
//
//   channel  | handshake                  | word
//   ---------+----------------------------+----------------------------------
//   item     | item_valid / item_stall    | command, char_value, last_char
//   result   | result_valid / result_stall| matched, pattern_overflow
//
// One word per cycle while item_stall is low, pattern or name byte alike;
// every cell updates its live bit in parallel, so the chain of PAT_MAX+1
// cells sets the single-cycle rate. The group stage registers the grouped OR
// of end hits with the cell update on the last name byte; the output register
// holds the final OR. Reset is synchronous; the pattern store needs no sweep.
// item_stall rises only when a result waits in the output register under
// result_stall and another one is held in the group stage behind it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module star_wildcard_matcher #(
  parameter int PAT_MAX = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  swm_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output swm_pkg::result_t result
);
  import swm_pkg::*;

  localparam int NCELL  = PAT_MAX + 1;
  localparam int LEN_W  = $clog2(PAT_MAX + 1);
  localparam int NGROUP = (NCELL + GROUP_SIZE - 1) / GROUP_SIZE;

  // Load and name control.
  logic             loading;
  logic             in_prog;
  logic             ovf;
  logic             last_star;
  logic [LEN_W-1:0] len;     // stored cells, star runs collapsed
  logic [LEN_W-1:0] raw;     // pattern bytes counted against capacity

  logic             accept;
  logic             pat_acc;
  logic             name_acc;
  logic             is_star;
  logic [LEN_W-1:0] base_len;
  logic [LEN_W-1:0] base_raw;
  logic             base_ovf;
  logic             base_last_star;
  logic             room;
  logic             keep;
  logic             wr_en;

  swm_bcast_t       bcast;
  swm_link_t        links [NCELL];
  logic [NCELL-1:0] wr_vec;
  logic [NCELL-1:0] hits;
  logic [NCELL-1:0] filled_vec;

  // Result pipeline.
  logic [NGROUP*GROUP_SIZE-1:0] hit_pad;
  logic [NGROUP-1:0]            part_next;
  logic [NGROUP-1:0]            p_part;
  logic                         p_valid;
  logic                         p_ovf;
  logic                         adv_p;

  // Hold input only when both result stages are occupied and blocked.
  assign adv_p      = p_valid && !(result_valid && result_stall);
  assign item_stall = p_valid && result_valid && result_stall;
  assign accept     = item_valid && !item_stall;
  assign pat_acc    = accept && (item.command == CMD_PATTERN);
  assign name_acc   = accept && (item.command == CMD_NAME);
  assign is_star    = (item.char_value == STAR_BYTE);

  // A pattern byte after a finished pattern or a name starts a new pattern.
  always_comb begin
    base_len       = loading ? '0 : len;
    base_raw       = loading ? '0 : raw;
    base_ovf       = loading ? 1'b0 : ovf;
    base_last_star = loading ? 1'b0 : last_star;
    room           = base_raw < LEN_W'(PAT_MAX);
    // Drop a star that follows a stored star: a** matches as a*.
    keep           = room && !(is_star && base_last_star);
    wr_en          = pat_acc && keep;
  end

  always_comb begin
    bcast.step  = name_acc;
    bcast.start = !in_prog;
    bcast.clear = pat_acc && loading;
    bcast.star  = is_star;
    bcast.ch    = item.char_value;
  end

  genvar k;
  generate
    for (k = 0; k < NCELL; k++) begin : g_cell
      logic start_live;

      assign wr_vec[k] = wr_en && (base_len == LEN_W'(k));

      if (k == 0) begin : g_first
        assign start_live = 1'b1;
        swm_cell u_cell (
          .clk        (clk),
          .rst        (rst),
          .bcast      (bcast),
          .wr         (wr_vec[k]),
          .start_live (start_live),
          .link_in    (LINK_HEAD),
          .link_out   (links[k]),
          .hit        (hits[k])
        );
      end else begin : g_rest
        // A leading star makes the second position live at name start.
        if (k == 1) begin : g_second
          assign start_live = links[0].star;
        end else begin : g_other
          assign start_live = 1'b0;
        end
        swm_cell u_cell (
          .clk        (clk),
          .rst        (rst),
          .bcast      (bcast),
          .wr         (wr_vec[k]),
          .start_live (start_live),
          .link_in    (links[k-1]),
          .link_out   (links[k]),
          .hit        (hits[k])
        );
      end

      assign filled_vec[k] = links[k].filled;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      loading   <= 1'b1;
      in_prog   <= 1'b0;
      ovf       <= 1'b0;
      last_star <= 1'b0;
      len       <= '0;
      raw       <= '0;
    end else if (pat_acc) begin
      in_prog   <= 1'b0;
      loading   <= item.last_char;
      raw       <= room ? base_raw + LEN_W'(1) : base_raw;
      ovf       <= base_ovf | !room;
      len       <= keep ? base_len + LEN_W'(1) : base_len;
      last_star <= keep ? is_star : base_last_star;
    end else if (name_acc) begin
      loading <= 1'b1;
      in_prog <= !item.last_char;
    end
  end

  // First half of the end-position OR: one bit per group of cells.
  always_comb begin
    hit_pad            = '0;
    hit_pad[NCELL-1:0] = hits;
    for (int g = 0; g < NGROUP; g++) begin
      part_next[g] = |hit_pad[g*GROUP_SIZE +: GROUP_SIZE];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (name_acc && item.last_char) begin
        p_valid <= 1'b1;
      end else if (adv_p) begin
        p_valid <= 1'b0;
      end
      if (adv_p) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
    if (name_acc && item.last_char) begin
      p_part <= part_next;
      p_ovf  <= ovf;
    end
    if (adv_p) begin
      result.matched          <= |p_part;
      result.pattern_overflow <= p_ovf;
    end
  end

  // Collapsed length never exceeds the raw byte count.
  `SWM_ASSERT_IMPLY(a_len_le_raw, 1'b1, len <= raw)
  // Filled cells form exactly the stored prefix.
  `SWM_ASSERT_IMPLY(a_filled_count, 1'b1, $countones(filled_vec) == int'(len))
  // Input is held back only while the output word waits.
  `SWM_ASSERT_IMPLY(a_stall_cause, item_stall, result_valid && result_stall)
  // The last name byte always produces a pending result.
  `SWM_ASSERT_NEXT(a_name_reports, name_acc && item.last_char, p_valid)
  // A pending result that can move shows up on the output next cycle.
  `SWM_ASSERT_NEXT(a_result_moves, adv_p, result_valid)

endmodule
